// ===== hdl/ntrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntrc_pkg
// Shared types and codes of the neighbor table with per-role counts.
// ----------------------------------------------------------------------------
package ntrc_pkg;

    localparam int ID_W     = 32;
    localparam int TIME_W   = 32;
    localparam int ROLE_W   = 3;
    localparam int DIST_W   = 8;
    localparam int PKT_W    = 32;
    localparam int WEIGHT_W = 8;

    localparam logic [WEIGHT_W-1:0] WEIGHT_START = 8'd128;
    localparam int                  ROLE_SLOTS   = 8;

    // input commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SWEEP  = 1'b1;

    // result status codes
    localparam logic [2:0] STAT_UPDATED = 3'd0;
    localparam logic [2:0] STAT_ADDED   = 3'd1;
    localparam logic [2:0] STAT_FULL    = 3'd2;
    localparam logic [2:0] STAT_IGNORED = 3'd3;
    localparam logic [2:0] STAT_SWEPT   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ID  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_QUEEN   = 2'd2;

    // shared compare unit operations
    localparam logic CMP_EQ  = 1'b0;   // a == b
    localparam logic CMP_AGE = 1'b1;   // (a - b) mod 2^32 > lim

    typedef struct packed {
        logic [PKT_W-1:0]    packets;
        logic [WEIGHT_W-1:0] weight;
        logic [DIST_W-1:0]   distance;
    } t_aux;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] seen_at;
        logic [ROLE_W-1:0] role;
        t_aux              aux;
    } t_entry;

    typedef struct packed {
        logic   rd_en;
        logic   wr_en;
        logic   clr_en;
        t_entry wr;
    } t_tbl_req;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_tbl_rd;

endpackage

// ===== hdl/ntrc_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// ntrc_cmp_unit
// Shared compare unit: id match or wrapped-age-over-limit test.
// ----------------------------------------------------------------------------
module ntrc_cmp_unit (
    input  logic                      i_op,
    input  logic [ntrc_pkg::ID_W-1:0] i_a,
    input  logic [ntrc_pkg::ID_W-1:0] i_b,
    input  logic [ntrc_pkg::ID_W-1:0] i_lim,
    output logic                      o_hit
);
    import ntrc_pkg::*;

    logic [ID_W-1:0] diff;

    assign diff = i_a - i_b;

    always_comb begin
        case (i_op)
            CMP_EQ:  o_hit = (i_a == i_b);
            CMP_AGE: o_hit = (diff > i_lim);
            default: o_hit = 1'b0;
        endcase
    end

endmodule

// ===== hdl/ntrc_table.sv =====
// ----------------------------------------------------------------------------
// ntrc_table
// Entry storage: one read and one write port, registered read, valid flops.
// ----------------------------------------------------------------------------
module ntrc_table #(
    parameter int DEPTH = 16,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ntrc_pkg::t_tbl_req i_req,
    input  logic [IW-1:0]      i_rd_addr,
    input  logic [IW-1:0]      i_wr_addr,
    output ntrc_pkg::t_tbl_rd  o_rd
);
    import ntrc_pkg::*;

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_tbl_rd          r_rd;

    // occupancy; a cleared slot reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end else if (i_req.clr_en) begin
            r_valid[i_wr_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_wr_addr] <= i_req.wr;
        end
        if (i_req.rd_en) begin
            r_rd.entry <= r_mem[i_rd_addr];
            r_rd.valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== hdl/neighbor_table_with_role_counts_top.sv =====
// ----------------------------------------------------------------------------
// neighbor_table_with_role_counts_top
// Neighbor table with aging, per-role counts, live count and queen tracking.
//
// An item is either a neighbor update or an expire sweep; each gives one
// result item. The block takes one item at a time and holds o_in_stall high
// until that item's result is loaded into the output register. Both kinds of
// item scan the table through its single read port, one entry per cycle,
// with the shared compare unit testing each entry as it comes back: an
// update stops its scan at the matching slot when it hits early, an ignored
// update (own id or id zero) skips the scan, and a sweep reads every slot.
// The result waits in the output register while the next item is accepted
// and scanned; the final table write waits only if that register is still
// full.
// ----------------------------------------------------------------------------
module neighbor_table_with_role_counts_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    // input item channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_command,
    input  logic [ntrc_pkg::ID_W-1:0]   i_neighbor_id,
    input  logic [ntrc_pkg::ROLE_W-1:0] i_neighbor_role,
    input  logic [ntrc_pkg::DIST_W-1:0] i_hop_distance,
    input  logic [ntrc_pkg::TIME_W-1:0] i_current_time,
    // result item channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_status,
    output logic [3:0]                  o_slot_index,
    output logic [4:0]                  o_expired_total,
    output logic [4:0]                  o_neighbor_total,
    output logic [ntrc_pkg::ID_W-1:0]   o_queen_id
);
    import ntrc_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);   // holds 0..TABLE_DEPTH

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    // configuration
    logic [ID_W-1:0]   r_own_id;
    logic [TIME_W-1:0] r_timeout;
    logic [ROLE_W-1:0] r_queen_role;

    // sequencer
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_issue, n_issue;   // next slot to read
    logic          r_dv, n_dv;         // read data in flight
    logic [IW-1:0] r_didx, n_didx;     // slot of read data

    // latched item
    logic              r_cmd, n_cmd;
    logic [ID_W-1:0]   r_id, n_id;
    logic [ROLE_W-1:0] r_role, n_role;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [TIME_W-1:0] r_now, n_now;
    logic              r_ign, n_ign;

    // scan findings
    logic              r_hit, n_hit;
    logic [IW-1:0]     r_slot, n_slot;
    logic              r_have_free, n_have_free;
    logic [IW-1:0]     r_free, n_free;
    logic [ROLE_W-1:0] r_old_role, n_old_role;
    t_aux              r_old_aux, n_old_aux;
    logic [CW-1:0]     r_freed, n_freed;

    // block state
    logic [CW-1:0]   r_live, n_live;
    logic [CW-1:0]   r_tally [ROLE_SLOTS];
    logic [CW-1:0]   n_tally [ROLE_SLOTS];
    logic [ID_W-1:0] r_queen, n_queen;

    // output register
    logic            r_out_valid, n_out_valid;
    logic [2:0]      r_o_status, n_o_status;
    logic [IW-1:0]   r_o_slot, n_o_slot;
    logic [CW-1:0]   r_o_expired, n_o_expired;
    logic [CW-1:0]   r_o_total, n_o_total;
    logic [ID_W-1:0] r_o_queen, n_o_queen;

    // table and compare unit hookup
    t_tbl_req      tbl_req;
    t_tbl_rd       tbl_rd;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          cmp_op;
    logic [ID_W-1:0] cmp_a;
    logic [ID_W-1:0] cmp_b;
    logic          cmp_hit;

    logic          in_accept;
    logic          stop;
    logic [IW-1:0] tgt;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    ntrc_table #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_rd      (tbl_rd)
    );

    // sweep: age of entry against timeout; update: id match
    assign cmp_op = r_cmd;
    assign cmp_a  = (r_cmd == CMD_SWEEP) ? r_now : tbl_rd.entry.id;
    assign cmp_b  = (r_cmd == CMD_SWEEP) ? tbl_rd.entry.seen_at : r_id;

    ntrc_cmp_unit u_cmp (
        .i_op  (cmp_op),
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .i_lim (r_timeout),
        .o_hit (cmp_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id     <= '0;
            r_timeout    <= 32'd500;
            r_queen_role <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWN_ID:  r_own_id     <= i_cfg_data;
                CFG_TIMEOUT: r_timeout    <= i_cfg_data;
                CFG_QUEEN:   r_queen_role <= i_cfg_data[ROLE_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_dv        = 1'b0;
        n_didx      = r_didx;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_role      = r_role;
        n_dist      = r_dist;
        n_now       = r_now;
        n_ign       = r_ign;
        n_hit       = r_hit;
        n_slot      = r_slot;
        n_have_free = r_have_free;
        n_free      = r_free;
        n_old_role  = r_old_role;
        n_old_aux   = r_old_aux;
        n_freed     = r_freed;
        n_live      = r_live;
        n_tally     = r_tally;
        n_queen     = r_queen;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_slot    = r_o_slot;
        n_o_expired = r_o_expired;
        n_o_total   = r_o_total;
        n_o_queen   = r_o_queen;
        tbl_req     = '0;
        rd_addr     = r_issue[IW-1:0];
        wr_addr     = r_didx;
        stop        = 1'b0;
        tgt         = r_slot;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd       = i_command;
                    n_id        = i_neighbor_id;
                    n_role      = i_neighbor_role;
                    n_dist      = i_hop_distance;
                    n_now       = i_current_time;
                    n_ign       = (i_command == CMD_UPDATE) &&
                                  ((i_neighbor_id == r_own_id) || (i_neighbor_id == '0));
                    n_issue     = '0;
                    n_hit       = 1'b0;
                    n_have_free = 1'b0;
                    n_free      = '0;
                    n_freed     = '0;
                    n_state     = n_ign ? S_APPLY : S_SCAN;
                end
            end

            S_SCAN: begin
                // look at the entry read last cycle
                if (r_dv) begin
                    if (r_cmd == CMD_UPDATE) begin
                        if (tbl_rd.valid && cmp_hit) begin
                            stop       = 1'b1;
                            n_hit      = 1'b1;
                            n_slot     = r_didx;
                            n_old_role = tbl_rd.entry.role;
                            n_old_aux  = tbl_rd.entry.aux;
                            n_state    = S_APPLY;
                        end else if (!tbl_rd.valid && !r_have_free) begin
                            n_have_free = 1'b1;
                            n_free      = r_didx;
                        end
                    end else if (tbl_rd.valid && cmp_hit) begin
                        tbl_req.clr_en = 1'b1;
                        if (tbl_rd.entry.role != '0 && n_tally[tbl_rd.entry.role] != '0) begin
                            n_tally[tbl_rd.entry.role] = n_tally[tbl_rd.entry.role] - 1'b1;
                        end
                        if (r_live != '0) begin
                            n_live = r_live - 1'b1;
                        end
                        n_freed = r_freed + 1'b1;
                    end
                end
                // read ahead one slot
                if (!stop && (r_issue < CW'(TABLE_DEPTH))) begin
                    tbl_req.rd_en = 1'b1;
                    n_issue       = r_issue + 1'b1;
                    n_didx        = r_issue[IW-1:0];
                    n_dv          = 1'b1;
                end
                if (!r_dv && (r_issue == CW'(TABLE_DEPTH))) begin
                    n_state = S_APPLY;
                end
            end

            S_APPLY: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_o_slot    = '0;
                    n_o_expired = '0;
                    if (r_cmd == CMD_SWEEP) begin
                        n_o_status  = STAT_SWEPT;
                        n_o_expired = r_freed;
                    end else if (r_ign) begin
                        n_o_status = STAT_IGNORED;
                    end else if (!r_hit && !r_have_free) begin
                        n_o_status = STAT_FULL;
                    end else begin
                        tbl_req.wr_en        = 1'b1;
                        tbl_req.wr.id        = r_id;
                        tbl_req.wr.seen_at   = r_now;
                        tbl_req.wr.role      = r_role;
                        if (r_hit) begin
                            tgt = r_slot;
                            // role count moves only on a role change
                            if (r_old_role != r_role) begin
                                if (r_old_role != '0 && n_tally[r_old_role] != '0) begin
                                    n_tally[r_old_role] = n_tally[r_old_role] - 1'b1;
                                end
                                if (r_role != '0 && n_tally[r_role] != '1) begin
                                    n_tally[r_role] = n_tally[r_role] + 1'b1;
                                end
                            end
                            tbl_req.wr.aux.packets = (r_old_aux.packets != '1) ?
                                                     r_old_aux.packets + 1'b1 :
                                                     r_old_aux.packets;
                            tbl_req.wr.aux.weight  = r_old_aux.weight;
                            n_o_status = STAT_UPDATED;
                        end else begin
                            tgt = r_free;
                            if (r_live != '1) begin
                                n_live = r_live + 1'b1;
                            end
                            if (r_role != '0 && n_tally[r_role] != '1) begin
                                n_tally[r_role] = n_tally[r_role] + 1'b1;
                            end
                            tbl_req.wr.aux.packets = PKT_W'(1);
                            tbl_req.wr.aux.weight  = WEIGHT_START;
                            n_o_status = STAT_ADDED;
                        end
                        tbl_req.wr.aux.distance = r_dist;
                        wr_addr  = tgt;
                        n_o_slot = tgt;
                        if (r_role == r_queen_role) begin
                            n_queen = r_id;
                        end
                    end
                    n_o_total = n_live;
                    n_o_queen = n_queen;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dv        <= 1'b0;
            r_live      <= '0;
            r_tally     <= '{default: '0};
            r_queen     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dv        <= n_dv;
            r_live      <= n_live;
            r_tally     <= n_tally;
            r_queen     <= n_queen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue     <= n_issue;
        r_didx      <= n_didx;
        r_cmd       <= n_cmd;
        r_id        <= n_id;
        r_role      <= n_role;
        r_dist      <= n_dist;
        r_now       <= n_now;
        r_ign       <= n_ign;
        r_hit       <= n_hit;
        r_slot      <= n_slot;
        r_have_free <= n_have_free;
        r_free      <= n_free;
        r_old_role  <= n_old_role;
        r_old_aux   <= n_old_aux;
        r_freed     <= n_freed;
        r_o_status  <= n_o_status;
        r_o_slot    <= n_o_slot;
        r_o_expired <= n_o_expired;
        r_o_total   <= n_o_total;
        r_o_queen   <= n_o_queen;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_slot_index     = 4'(r_o_slot);
    assign o_expired_total  = 5'(r_o_expired);
    assign o_neighbor_total = 5'(r_o_total);
    assign o_queen_id       = r_o_queen;

`ifndef SYNTHESIS
    // in the cycle after an item is accepted the block is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // read data in flight always belongs to the slot just before the read pointer
    a_scan_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_dv) |-> (r_issue == CW'(r_didx) + 1'b1))
        else $error("scan pointer and data slot out of step");

    // live count bounded by table size
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(TABLE_DEPTH))
        else $error("live count exceeds table depth");

    // a newly added neighbor leaves at least one live entry
    a_added_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status == STAT_ADDED) |-> (r_o_total != '0))
        else $error("added neighbor with zero live count");

    // the ignore path never reports a matched slot
    a_ign_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_ign && r_cmd == CMD_UPDATE) |-> !r_hit)
        else $error("ignored update found a hit");
`endif

endmodule

// ===== tb/neighbor_table_model_pkg.sv =====
// ----------------------------------------------------------------------------
// neighbor_table_model_pkg
// Result predictor and in-order checker for the neighbor table.
// Only the state that reaches the result fields is modeled: entry ids,
// last-seen times, the live count and the queen id.
// ----------------------------------------------------------------------------
package neighbor_table_model_pkg;

    import ntrc_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [4:0]  expired;
        logic [4:0]  total;
        logic [31:0] queen;
    } t_answer;

    class neighbor_table_model;

        logic [31:0] own_id;
        logic [31:0] timeout;
        logic [2:0]  queen_role;

        logic [31:0] slot_id[SLOTS];
        logic [31:0] slot_seen[SLOTS];
        int unsigned live;
        logic [31:0] queen_ident;

        t_answer     answers_due[$];
        int unsigned mismatches;

        function new();
            own_id      = '0;
            timeout     = 32'd500;
            queen_role  = 3'd4;
            live        = 0;
            queen_ident = '0;
            mismatches  = 0;
            foreach (slot_id[k]) slot_id[k] = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_OWN_ID:  own_id = data;
                CFG_TIMEOUT: timeout = data;
                CFG_QUEEN:   queen_role = data[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        // accepted item: advance the table and queue the result it causes
        function void take_item(logic cmd, logic [31:0] id, logic [2:0] role,
                                logic [31:0] tick);
            t_answer     want;
            logic [31:0] age;
            int          slot_no;
            int          free_no;
            want = '0;
            if (cmd == CMD_SWEEP) begin
                want.status = STAT_SWEPT;
                for (int k = 0; k < SLOTS; k++) begin
                    age = tick - slot_seen[k];
                    if (slot_id[k] != '0 && age > timeout) begin
                        slot_id[k] = '0;
                        live--;
                        want.expired++;
                    end
                end
            end else if (id == own_id || id == '0) begin
                want.status = STAT_IGNORED;
            end else begin
                slot_no = -1;
                free_no = -1;
                // a match anywhere beats the first free slot
                for (int k = 0; k < SLOTS && slot_no < 0; k++) begin
                    if (slot_id[k] == id)
                        slot_no = k;
                    else if (slot_id[k] == '0 && free_no < 0)
                        free_no = k;
                end
                if (slot_no >= 0) begin
                    want.status = STAT_UPDATED;
                end else if (free_no >= 0) begin
                    slot_no     = free_no;
                    live++;
                    want.status = STAT_ADDED;
                end else begin
                    want.status = STAT_FULL;
                end
                if (slot_no >= 0) begin
                    slot_id[slot_no]   = id;
                    slot_seen[slot_no] = tick;
                    want.slot          = 4'(slot_no);
                    if (role == queen_role)
                        queen_ident = id;
                end
            end
            want.total = 5'(live);
            want.queen = queen_ident;
            answers_due.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // accepted result: compare with the oldest outstanding prediction
        function void check_answer(logic [2:0] status, logic [3:0] slot,
                                   logic [4:0] expired, logic [4:0] total,
                                   logic [31:0] queen);
            t_answer want;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, got status %0h",
                         $time, status);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            compare_field("status", 32'(want.status), 32'(status));
            compare_field("slot_index", 32'(want.slot), 32'(slot));
            compare_field("expired_total", 32'(want.expired), 32'(expired));
            compare_field("neighbor_total", 32'(want.total), 32'(total));
            compare_field("queen_id", want.queen, queen);
        endfunction

    endclass

endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the neighbor table with per-role counts: a short
// directed run on the reset settings, then six random phases under
// different own id, timeout and queen role settings, with random idling on
// both channels. Every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;

    import ntrc_pkg::*;
    import neighbor_table_model_pkg::*;

    localparam int RUN_LIMIT = 400000;  // cycles; slowest legal run is far below
    localparam int SETTLE    = 24;      // a full scan plus margin
    localparam int LONG_HOLD = 300;     // receiver back-pressure stretch

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_command;
    logic [31:0] i_neighbor_id;
    logic [2:0]  i_neighbor_role;
    logic [7:0]  i_hop_distance;
    logic [31:0] i_current_time;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [3:0]  o_slot_index;
    logic [4:0]  o_expired_total;
    logic [4:0]  o_neighbor_total;
    logic [31:0] o_queen_id;

    neighbor_table_model table_model = new();

    int unsigned cycle_count = 0;
    bit          rx_long_hold = 1'b0;  // raised by the stimulus, cleared by the receiver
    bit          quiet = 1'b0;         // no idling on either side while set
    logic [31:0] now_tick;

    neighbor_table_with_role_counts_top #(
        .TABLE_DEPTH(SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_neighbor_id   (i_neighbor_id),
        .i_neighbor_role (i_neighbor_role),
        .i_hop_distance  (i_hop_distance),
        .i_current_time  (i_current_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_expired_total (o_expired_total),
        .o_neighbor_total(o_neighbor_total),
        .o_queen_id      (o_queen_id)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Handshakes are observed at the rising edge, before any register in the
    // block updates. The result check runs first so that an item accepted on
    // the same edge cannot be mistaken for the one being answered.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                table_model.check_answer(o_status, o_slot_index, o_expired_total,
                                         o_neighbor_total, o_queen_id);
            if (i_in_valid && !o_in_stall)
                table_model.take_item(i_command, i_neighbor_id, i_neighbor_role,
                                      i_current_time);
        end
    end

    // Result side: before each result, stall for a drawn number of cycles,
    // then take the result as soon as it shows. A long hold requested by the
    // stimulus replaces one draw, so the block fills and stalls its input.
    initial begin : receiver
        int unsigned hold;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_long_hold) begin
                hold         = LONG_HOLD;
                rx_long_hold = 1'b0;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 18);
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Called on a falling edge; returns on the falling edge after the item is
    // taken, with valid still high so a back-to-back item keeps it that way.
    task automatic send_item(input logic cmd, input logic [31:0] id,
                             input logic [2:0] role, input logic [7:0] hop,
                             input logic [31:0] tick);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_neighbor_id   <= id;
        i_neighbor_role <= role;
        i_hop_distance  <= hop;
        i_current_time  <= tick;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    // Sender pause: no item offered until every result is back and the last
    // table write has surely landed.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (table_model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // All three registers, one per cycle, only while the block is idle.
    task automatic configure(input logic [31:0] own, input logic [31:0] limit,
                             input logic [2:0] queen);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OWN_ID;
        i_cfg_data  <= own;
        @(negedge i_clk);
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= limit;
        @(negedge i_clk);
        i_cfg_index <= CFG_QUEEN;
        i_cfg_data  <= {29'd0, queen};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        table_model.set_register(CFG_OWN_ID, own);
        table_model.set_register(CFG_TIMEOUT, limit);
        table_model.set_register(CFG_QUEEN, {29'd0, queen});
    endtask

    // Random traffic. Most updates come from a small pool of neighbors so that
    // entries get refreshed, aged out and (with a large pool) fill the table;
    // the rest hit the own id, id zero or a fresh random id.
    // step_max of zero means the clock jumps anywhere on each item.
    task automatic random_phase(input int unsigned count, input int unsigned step_max,
                                input int unsigned pool_size,
                                input int unsigned sweep_odds);
        logic [31:0] pool[24];
        logic [31:0] id;
        logic        cmd;
        int unsigned pick;
        for (int k = 0; k < 24; k++)
            pool[k] = (k < 4) ? 32'(k + 1) : $urandom();
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            cmd  = ($urandom_range(0, sweep_odds - 1) == 0) ? CMD_SWEEP : CMD_UPDATE;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                id = pool[$urandom_range(0, pool_size - 1)];
            else if (pick < 80)
                id = table_model.own_id;
            else if (pick < 85)
                id = '0;
            else
                id = $urandom();
            // a rare jump, backwards included, ages entries arbitrarily
            if (step_max == 0 || $urandom_range(0, 49) == 0)
                now_tick = $urandom();
            else
                now_tick = now_tick + $urandom_range(0, step_max);
            send_item(cmd, id, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      now_tick);
        end
        quiet = 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_OWN_ID;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_command       = CMD_UPDATE;
        i_neighbor_id   = '0;
        i_neighbor_role = '0;
        i_hop_distance  = '0;
        i_current_time  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed, on reset settings: own id 0, timeout 500, queen role 4
        // id zero (also the own id here) is ignored
        send_item(CMD_UPDATE, 32'd0, 3'd4, 8'd0, 32'hFFFF_FF00);
        // all-ones fields: new neighbor in slot 0
        send_item(CMD_UPDATE, 32'hFFFF_FFFF, 3'd7, 8'hFF, 32'hFFFF_FF00);
        // queen role: new neighbor in slot 1 becomes the queen
        send_item(CMD_UPDATE, 32'd1, 3'd4, 8'd0, 32'hFFFF_FF80);
        // refresh with the same role
        send_item(CMD_UPDATE, 32'd1, 3'd4, 8'd9, 32'hFFFF_FF90);
        // role falls to the uncounted code, queen id stays
        send_item(CMD_UPDATE, 32'd1, 3'd0, 8'd9, 32'hFFFF_FFA0);
        // clock wraps past all ones
        send_item(CMD_UPDATE, 32'hFFFF_FFFF, 3'd3, 8'd1, 32'h0000_0010);
        // age equal to the timeout survives; slot 1 is older and goes
        send_item(CMD_SWEEP, 32'd0, 3'd0, 8'd0, 32'h0000_0010 + 32'd500);
        // one tick more and slot 0 goes too
        send_item(CMD_SWEEP, 32'hFFFF_FFFF, 3'd7, 8'hFF, 32'h0000_0010 + 32'd501);
        // matching entry found past a free slot: id 3 must stay in slot 1
        send_item(CMD_UPDATE, 32'd2, 3'd1, 8'd5, 32'd1000);
        send_item(CMD_UPDATE, 32'd3, 3'd7, 8'd6, 32'd1300);
        send_item(CMD_SWEEP, 32'd0, 3'd0, 8'd0, 32'd1501);
        send_item(CMD_UPDATE, 32'd3, 3'd4, 8'd7, 32'd1510);
        send_item(CMD_UPDATE, 32'd4, 3'd2, 8'd8, 32'd1520);
        // sweep at time zero: the wrapped ages exceed the timeout, so every entry goes
        send_item(CMD_SWEEP, 32'd0, 3'd0, 8'd0, 32'd0);
        now_tick = 32'd1520;
        drain();

        // --- random phases; each starts from an idle block
        configure(32'd0, 32'd500, 3'd4);
        rx_long_hold = 1'b1;            // back-pressure early in this phase
        random_phase(150, 120, 18, 12);
        drain();

        // timeout at its top: nothing ever expires, so the table fills
        configure($urandom(), 32'hFFFF_FFFF, 3'd7);
        random_phase(150, 0, 24, 12);
        drain();

        // timeout zero: any tick of age is stale
        configure(32'hFFFF_FFFF, 32'd0, 3'd1);
        random_phase(150, 2, 10, 6);
        drain();

        configure($urandom(), $urandom(), 3'($urandom_range(1, 7)));
        random_phase(150, 0, 16, 10);
        drain();

        configure(32'd0, 32'd1000, 3'd2);
        rx_long_hold = 1'b1;
        random_phase(150, 300, 20, 12);
        drain();

        configure($urandom(), 32'd50, 3'd3);
        random_phase(150, 20, 12, 8);
        drain();

        if (table_model.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
